/* rtl/vlbp_pkg.sv */
// Shared constants and types for the variable-length bit packer.
package vlbp_pkg;

	localparam int CELL_W      = 16;  // cell_value field width
	localparam int LEN_W       = 5;   // bit length of a cell, 0..CELL_W
	localparam int OUT_WORD_W  = 64;  // packed_word field width
	localparam int VBITS_W     = 7;   // valid_bits field width
	localparam int OUT_TDATA_W = 72;  // packed_word + valid_bits, padded to bytes
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// One classified cell travelling from front to back.
	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic [LEN_W-1:0]  len;
		logic              last;
	} cell_ent_t;

endpackage

/* rtl/vlbp_front.sv */
// Front stage: takes input beats, masks the value and finds its bit length.
module vlbp_front #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [vlbp_pkg::CELL_W-1:0] s_tdata,
	input  logic                        s_tlast,
	output logic                        ent_valid,
	input  logic                        ent_ready,
	output vlbp_pkg::cell_ent_t         ent
);
	import vlbp_pkg::*;

	logic              valid_s1;
	cell_ent_t         ent_s1;
	logic [CELL_W-1:0] val_m;
	logic [LEN_W-1:0]  len_c;

	// drop bits at and above VALUE_WIDTH
	always_comb begin
		for (int i = 0; i < CELL_W; i++) begin
			val_m[i] = s_tdata[i] && (i < VALUE_WIDTH);
		end
	end

	// highest set bit + 1
	always_comb begin
		len_c = '0;
		for (int i = 0; i < CELL_W; i++) begin
			if (val_m[i]) begin
				len_c = LEN_W'(i + 1);
			end
		end
	end

	assign s_tready  = !valid_s1 || ent_ready;
	assign ent_valid = valid_s1;
	assign ent       = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ent_s1.value <= val_m;
			ent_s1.len   <= len_c;
			ent_s1.last  <= s_tlast;
		end
	end

endmodule

/* rtl/vlbp_queue.sv */
// Short FIFO of classified cells between front and back.
module vlbp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vlbp_pkg::cell_ent_t in_ent,
	output logic                out_valid,
	input  logic                out_pop,
	output vlbp_pkg::cell_ent_t out_ent
);
	import vlbp_pkg::*;

	cell_ent_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	assign in_ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_ent   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !out_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && out_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_ent;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_pop |-> cnt_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

/* rtl/vlbp_back.sv */
// Back stage: shifts cells into the accumulator and emits full and flush words.
module vlbp_back #(
	parameter int WORD_WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  vlbp_pkg::cell_ent_t              q_ent,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vlbp_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast
);
	import vlbp_pkg::*;

	localparam int FILL_W = $clog2(WORD_WIDTH);
	localparam int SUM_W  = FILL_W + 1;
	localparam int ACC_W  = WORD_WIDTH + CELL_W;

	logic [WORD_WIDTH-1:0] pend_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  o_valid_q;
	logic [OUT_WORD_W-1:0] o_word_q;
	logic [VBITS_W-1:0]    o_bits_q;
	logic                  o_last_q;
	logic                  x_valid_q;   // flush word waiting behind a full word
	logic [OUT_WORD_W-1:0] x_word_q;
	logic [VBITS_W-1:0]    x_bits_q;

	logic                  o_free;
	logic [ACC_W-1:0]      wide;
	logic [SUM_W-1:0]      sum;
	logic                  wrap;
	logic [WORD_WIDTH-1:0] next_pend;
	logic [FILL_W-1:0]     next_fill;

	assign o_free = !o_valid_q || m_tready;
	assign q_pop  = q_valid && !x_valid_q && o_free;

	assign wide      = ACC_W'(pend_q) | (ACC_W'(q_ent.value) << fill_q);
	assign sum       = SUM_W'(fill_q) + SUM_W'(q_ent.len);
	assign wrap      = (sum >= SUM_W'(WORD_WIDTH));

	always_comb begin
		if (wrap) begin
			next_pend = WORD_WIDTH'(wide >> WORD_WIDTH);
			next_fill = FILL_W'(sum - SUM_W'(WORD_WIDTH));
		end else begin
			next_pend = wide[WORD_WIDTH-1:0];
			next_fill = FILL_W'(sum);
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {1'b0, o_bits_q, o_word_q};
	assign m_tlast  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			fill_q    <= '0;
			o_valid_q <= 1'b0;
			x_valid_q <= 1'b0;
		end else begin
			if (x_valid_q && o_free) begin
				o_valid_q <= 1'b1;
				x_valid_q <= 1'b0;
			end else if (q_pop) begin
				o_valid_q <= wrap || q_ent.last;
				x_valid_q <= wrap && q_ent.last;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_ent.last) begin
					pend_q <= '0;
					fill_q <= '0;
				end else begin
					pend_q <= next_pend;
					fill_q <= next_fill;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (x_valid_q && o_free) begin
			o_word_q <= x_word_q;
			o_bits_q <= x_bits_q;
			o_last_q <= 1'b1;
		end else if (q_pop) begin
			if (wrap) begin
				o_word_q <= OUT_WORD_W'(wide[WORD_WIDTH-1:0]);
				o_bits_q <= VBITS_W'(WORD_WIDTH);
				o_last_q <= 1'b0;
			end else begin
				o_word_q <= OUT_WORD_W'(next_pend);
				o_bits_q <= VBITS_W'(next_fill);
				o_last_q <= 1'b1;
			end
			x_word_q <= OUT_WORD_W'(next_pend);
			x_bits_q <= VBITS_W'(next_fill);
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(fill_q) < SUM_W'(WORD_WIDTH))
		else $error("fill count reached word width");
	a_flush_behind_full: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid_q |-> o_valid_q && !o_last_q)
		else $error("held flush word without a full word ahead");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_ent.last |=> fill_q == '0 && pend_q == '0)
		else $error("accumulator not cleared after last cell");
`endif

endmodule

/* rtl/variable_length_bit_packer_core.sv */
// Top level of the variable-length bit packer.
// Each input beat carries one cell value; the block appends its significant bits
// (highest set bit + 1 of them, none for a zero value), least significant first, to a
// running bit stream and sends out a WORD_WIDTH-bit word each time one fills up, with
// valid_bits = WORD_WIDTH. A beat with tlast also flushes the partial word (possibly
// empty, valid_bits = 0) with tlast set on the output, and the accumulator starts over.
// One input beat can cause up to two output beats: a full word followed by the flush
// word. Input bits at and above VALUE_WIDTH are ignored. From input accept, a cell passes
// the classify register, the queue and the output register before its first output beat.
// Sustained rate is one beat per cycle on both sides while the output is not stalled; the
// packer holds its queue when a last beat also completes a word, as the single output
// register then carries two beats. A four-entry queue between the classifier and the
// packer absorbs that hold and output back-pressure. No clearing pass after reset.
module variable_length_bit_packer_core #(
	parameter int VALUE_WIDTH = 16,
	parameter int WORD_WIDTH  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [vlbp_pkg::CELL_W-1:0]      s_tdata,   // [15:0] cell_value
	input  logic                             s_tlast,   // last_cell
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vlbp_pkg::OUT_TDATA_W-1:0] m_tdata,   // [63:0] packed_word, [70:64] valid_bits
	output logic                             m_tlast    // last_word
);
	import vlbp_pkg::*;

	logic      f_valid;
	logic      f_ready;
	cell_ent_t f_ent;
	logic      q_valid;
	logic      q_pop;
	cell_ent_t q_ent;

	// classify: mask and bit length
	vlbp_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.ent_valid(f_valid),
		.ent_ready(f_ready),
		.ent      (f_ent)
	);

	// decouples front from back
	vlbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_ent   (f_ent),
		.out_valid(q_valid),
		.out_pop  (q_pop),
		.out_ent  (q_ent)
	);

	// barrel shift into the accumulator, emit words
	vlbp_back #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_ent   (q_ent),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

/* dv/vlbp_checker.sv */
// Stream monitor for the bit packer: predicts packed words from input beats and checks outputs.
module vlbp_checker #(
	parameter int VALUE_WIDTH = 16,
	parameter int WORD_WIDTH  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [vlbp_pkg::CELL_W-1:0]      s_tdata,
	input  logic                             s_tlast,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [vlbp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tlast,
	output int                               fail_count,
	output int                               words_outstanding
);
	import vlbp_pkg::*;

	typedef struct packed {
		logic [OUT_WORD_W-1:0] word;
		logic [VBITS_W-1:0]    nbits;
		logic                  last;
	} packed_word_t;

	packed_word_t          expected_words[$];
	logic [OUT_WORD_W-1:0] gathered_bits;  // stream bits not yet sent out
	int unsigned           gathered_cnt;

	function automatic int unsigned sig_len(logic [OUT_WORD_W-1:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < VALUE_WIDTH; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	// Append one cell to the predicted stream and queue the words it completes.
	task automatic pack_cell(input logic [CELL_W-1:0] raw, input logic is_last);
		logic [OUT_WORD_W-1:0] cval;
		logic [OUT_WORD_W-1:0] merged;
		logic [OUT_WORD_W-1:0] wmask;
		int unsigned           len;
		int unsigned           used;
		packed_word_t          w;
		cval  = OUT_WORD_W'(raw) & ((64'd1 << VALUE_WIDTH) - 64'd1);
		len   = sig_len(cval);
		wmask = (WORD_WIDTH >= 64) ? '1 : ((64'd1 << WORD_WIDTH) - 64'd1);
		if (len > 0) begin
			merged = (gathered_bits | (cval << gathered_cnt)) & wmask;
			if (gathered_cnt + len >= WORD_WIDTH) begin
				w.word  = merged;
				w.nbits = VBITS_W'(WORD_WIDTH);
				w.last  = 1'b0;
				expected_words.push_back(w);
				// bits that did not fit spill into the next word
				used          = WORD_WIDTH - gathered_cnt;
				gathered_bits = cval >> used;
				gathered_cnt  = len - used;
			end else begin
				gathered_bits = merged;
				gathered_cnt  = gathered_cnt + len;
			end
		end
		if (is_last) begin
			// flush goes out even when empty
			w.word  = gathered_bits;
			w.nbits = VBITS_W'(gathered_cnt);
			w.last  = 1'b1;
			expected_words.push_back(w);
			gathered_bits = '0;
			gathered_cnt  = 0;
		end
	endtask

	always @(posedge clk) begin : monitor
		packed_word_t          exp_w;
		logic [OUT_WORD_W-1:0] got_word;
		logic [VBITS_W-1:0]    got_nbits;
		got_word  = m_tdata[OUT_WORD_W-1:0];
		got_nbits = m_tdata[OUT_WORD_W +: VBITS_W];
		if (!arst_n) begin
			expected_words.delete();
			gathered_bits = '0;
			gathered_cnt  = 0;
			fail_count    = 0;
		end else begin
			// an output beat can never stem from an input beat of the same edge
			if (s_tvalid && s_tready)
				pack_cell(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected beat, word %h valid_bits %0d last %b",
						$time, got_word, got_nbits, m_tlast);
				end else begin
					exp_w = expected_words.pop_front();
					if (got_word !== exp_w.word) begin
						fail_count++;
						$display("%0t: packed_word expected %h actual %h",
							$time, exp_w.word, got_word);
					end
					if (got_nbits !== exp_w.nbits) begin
						fail_count++;
						$display("%0t: valid_bits expected %0d actual %0d",
							$time, exp_w.nbits, got_nbits);
					end
					if (m_tlast !== exp_w.last) begin
						fail_count++;
						$display("%0t: last_word expected %b actual %b",
							$time, exp_w.last, m_tlast);
					end
				end
			end
		end
		words_outstanding = expected_words.size();
	end

endmodule

/* dv/tb_top.sv */
// Top of the bit packer testbench: clock, reset, beat stimulus, back-pressure and verdict.
module tb_top;
	import vlbp_pkg::*;

	localparam int VALUE_WIDTH = 16;
	localparam int WORD_WIDTH  = 64;
	localparam int ITEM_TARGET = 650;
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 160;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [CELL_W-1:0]      s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	int fail_count;
	int words_outstanding;
	int hold_requests;   // bumped by the sender to ask for a long receiver stall
	bit sender_calm;     // no idle cycles on the input side
	bit receiver_calm;   // no idle cycles on the output side

	variable_length_bit_packer_core #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	vlbp_checker #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.fail_count       (fail_count),
		.words_outstanding(words_outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offer one beat and hold it until accepted; random idle cycles go ahead of it.
	task automatic send_cell(input logic [CELL_W-1:0] val, input logic lst);
		while (!sender_calm && $urandom_range(99) < 26) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Random bit length first for most cells; one in eight is a raw random value.
	function automatic logic [CELL_W-1:0] random_cell();
		int unsigned       nb;
		logic [CELL_W-1:0] r;
		r = CELL_W'($urandom);
		if ($urandom_range(7) == 0) return r;
		nb = $urandom_range(CELL_W, 0);
		if (nb == 0) return '0;
		r = r & CELL_W'((32'd1 << nb) - 32'd1);
		r[nb-1] = 1'b1;
		return r;
	endfunction

	initial begin : receiver
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left  = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests > holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= receiver_calm || ($urandom_range(99) >= 26);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int stream_no;
		int run_len;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		hold_requests = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty stream: flush with no bits
		send_cell(16'h0000, 1'b1);
		// single bit
		send_cell(16'h0001, 1'b1);
		// exactly one word with no spill, then an empty flush
		repeat (4) send_cell(16'hFFFF, 1'b0);
		send_cell(16'h0000, 1'b1);
		// word completes exactly on the last beat: full word plus empty flush
		repeat (3) send_cell(16'h8000, 1'b0);
		send_cell(16'hABCD, 1'b1);
		// word completes on the last beat with spill: full word plus 1-bit flush
		send_cell(16'h0001, 1'b0);
		repeat (3) send_cell(16'hFFFF, 1'b0);
		send_cell(16'hFFFF, 1'b1);
		// zero in mid-stream adds nothing
		send_cell(16'h0005, 1'b0);
		send_cell(16'h0000, 1'b0);
		send_cell(16'h0002, 1'b1);
		// 63 bits, one short of a full word, flushed by a zero last beat
		send_cell(16'h7FFF, 1'b0);
		repeat (3) send_cell(16'hC3A5, 1'b0);
		send_cell(16'h0000, 1'b1);

		sent      = 0;
		stream_no = 0;
		while (sent < ITEM_TARGET) begin
			stream_no++;
			sender_calm   = (stream_no >= 12 && stream_no <= 16);
			receiver_calm = sender_calm;
			if (stream_no == 4) hold_requests++;
			if (stream_no == 8) begin
				// drop the last beat before pausing so it is not taken again
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (words_outstanding == 0);
			end
			run_len = ($urandom_range(9) == 0) ? $urandom_range(120, 60)
				: $urandom_range(30, 1);
			if (run_len > ITEM_TARGET - sent) run_len = ITEM_TARGET - sent;
			for (int i = 0; i < run_len; i++) begin
				send_cell(random_cell(), i == run_len - 1);
				sent++;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait (words_outstanding == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && words_outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
